[src/i2cmbs_pkg.sv]
`default_nettype none

package i2cmbs_pkg;

    // Request codes on the input channel; codes above REQ_READ act as a tick
    localparam logic [2:0] REQ_TICK  = 3'd0;
    localparam logic [2:0] REQ_START = 3'd1;
    localparam logic [2:0] REQ_STOP  = 3'd2;
    localparam logic [2:0] REQ_WRITE = 3'd3;
    localparam logic [2:0] REQ_READ  = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_START_STOP_TICKS = 2'd0;
    localparam logic [1:0] CFG_HALF_BIT_TICKS   = 2'd1;
    localparam logic [1:0] CFG_ACK_TIMEOUT      = 2'd2;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 10;

    localparam logic [7:0] RST_START_STOP_TICKS = 8'd4;
    localparam logic [7:0] RST_HALF_BIT_TICKS   = 8'd2;
    localparam logic [9:0] RST_ACK_TIMEOUT      = 10'd250;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_START_A  = 4'd1,
        PH_START_B  = 4'd2,
        PH_STOP_A   = 4'd3,
        PH_STOP_B   = 4'd4,
        PH_WR_LOW   = 4'd5,
        PH_WR_HIGH  = 4'd6,
        PH_ACK_LOW  = 4'd7,
        PH_ACK_HIGH = 4'd8,
        PH_RD_LOW   = 4'd9,
        PH_RD_HIGH  = 4'd10,
        PH_RA_LOW   = 4'd11,
        PH_RA_HIGH  = 4'd12
    } t_phase;

endpackage

`default_nettype wire

[src/i2c_master_bit_sequencer.sv]
// I2C master bit engine. The input channel carries one item per transfer:
// a time tick or a command (start, stop, write byte, read byte). A command
// is taken only while the engine is idle; one that arrives while a sequence
// runs is dropped and answered with rejected set. Ticks step SCL and SDA
// through start, stop, eight data bits MSB first and the acknowledge bit.
// Every accepted item produces exactly one result transfer on the output
// channel carrying the pin levels, busy, done, ack_failed, read_data and
// rejected as they stand after that item.
// The state update and the result are computed in the accept cycle
// and the result register shows it the next cycle. Throughput is one
// item per cycle; the result register takes a new result in the same
// cycle that the old one is taken, so a stalled receiver holds the input
// ready low only while the result register is full and not taken.
// Reset (synchronous, active low) leaves the bus lines high and driven, the
// engine idle, the output channel empty and the registers at 4, 2 and 250.
// Configuration writes take effect at once and are meant for idle periods.
`default_nettype none

module i2c_master_bit_sequencer (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [i2cmbs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [i2cmbs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic [2:0]                          i_req_type,
    input  wire logic [7:0]                          i_tx_byte,
    input  wire logic                                i_send_nack,
    input  wire logic                                i_sda_sampled,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic                                     o_scl_level,
    output logic                                     o_sda_level,
    output logic                                     o_sda_drive,
    output logic                                     o_busy_res,
    output logic                                     o_done_res,
    output logic                                     o_ack_failed,
    output logic [7:0]                               o_read_data,
    output logic                                     o_rejected
);

    logic [7:0] r_sst;
    logic [7:0] r_half;
    logic [9:0] r_timeout;

    i2cmbs_pkg::t_phase r_phase, n_phase;
    logic [3:0] r_bit, n_bit;
    logic [7:0] r_tick, n_tick;
    logic [9:0] r_wait, n_wait;
    logic [7:0] r_shift, n_shift;
    logic       r_scl, n_scl;
    logic       r_sda, n_sda;
    logic       r_drive, n_drive;
    logic       r_nack, n_nack;
    logic       r_fail, n_fail;
    logic [7:0] r_rx, n_rx;
    logic       n_done, n_rej;

    logic       w_accept;

    assign o_in_ready = !o_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sst     <= i2cmbs_pkg::RST_START_STOP_TICKS;
            r_half    <= i2cmbs_pkg::RST_HALF_BIT_TICKS;
            r_timeout <= i2cmbs_pkg::RST_ACK_TIMEOUT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                i2cmbs_pkg::CFG_START_STOP_TICKS: r_sst     <= i_cfg_data[7:0];
                i2cmbs_pkg::CFG_HALF_BIT_TICKS:   r_half    <= i_cfg_data[7:0];
                i2cmbs_pkg::CFG_ACK_TIMEOUT:      r_timeout <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        logic [7:0]         v_sst;
        logic [7:0]         v_half;
        logic [7:0]         v_len;
        logic [9:0]         v_to;
        logic [8:0]         v_elapsed;
        logic               v_enter;
        i2cmbs_pkg::t_phase v_enter_ph;
        logic               v_is_cmd;

        v_sst      = (r_sst == 8'd0) ? 8'd1 : r_sst;
        v_half     = (r_half == 8'd0) ? 8'd1 : r_half;
        v_to       = (r_timeout == 10'd0) ? 10'd1 : r_timeout;
        v_len      = (r_phase == i2cmbs_pkg::PH_START_A || r_phase == i2cmbs_pkg::PH_START_B ||
                      r_phase == i2cmbs_pkg::PH_STOP_A  || r_phase == i2cmbs_pkg::PH_STOP_B)
                     ? v_sst : v_half;
        v_elapsed  = {1'b0, r_tick} + 9'd1;
        v_enter    = 1'b0;
        v_enter_ph = r_phase;
        v_is_cmd   = (i_req_type == i2cmbs_pkg::REQ_START) ||
                     (i_req_type == i2cmbs_pkg::REQ_STOP)  ||
                     (i_req_type == i2cmbs_pkg::REQ_WRITE) ||
                     (i_req_type == i2cmbs_pkg::REQ_READ);

        n_phase = r_phase;
        n_bit   = r_bit;
        n_tick  = r_tick;
        n_wait  = r_wait;
        n_shift = r_shift;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_drive = r_drive;
        n_nack  = r_nack;
        n_fail  = r_fail;
        n_rx    = r_rx;
        n_done  = 1'b0;
        n_rej   = 1'b0;

        if (w_accept) begin
            if (v_is_cmd) begin
                if (r_phase != i2cmbs_pkg::PH_IDLE) begin
                    n_rej = 1'b1;
                end else begin
                    n_fail  = 1'b0;
                    n_bit   = 4'd0;
                    v_enter = 1'b1;
                    unique case (i_req_type)
                        i2cmbs_pkg::REQ_START: v_enter_ph = i2cmbs_pkg::PH_START_A;
                        i2cmbs_pkg::REQ_STOP:  v_enter_ph = i2cmbs_pkg::PH_STOP_A;
                        i2cmbs_pkg::REQ_WRITE: begin
                            n_shift    = i_tx_byte;
                            v_enter_ph = i2cmbs_pkg::PH_WR_LOW;
                        end
                        default: begin
                            n_nack     = i_send_nack;
                            n_shift    = 8'd0;
                            v_enter_ph = i2cmbs_pkg::PH_RD_LOW;
                        end
                    endcase
                end
            end else if (r_phase == i2cmbs_pkg::PH_IDLE) begin
                n_phase = i2cmbs_pkg::PH_IDLE;
            end else if (r_phase == i2cmbs_pkg::PH_ACK_HIGH) begin
                if (!i_sda_sampled) begin
                    n_scl   = 1'b0;
                    n_phase = i2cmbs_pkg::PH_IDLE;
                    n_done  = 1'b1;
                end else begin
                    n_wait = r_wait + 10'd1;
                    // timeout: flag it and close the bus with a stop
                    if (n_wait >= v_to) begin
                        n_fail     = 1'b1;
                        v_enter    = 1'b1;
                        v_enter_ph = i2cmbs_pkg::PH_STOP_A;
                    end
                end
            end else if (v_elapsed < {1'b0, v_len}) begin
                n_tick = v_elapsed[7:0];
            end else begin
                unique case (r_phase)
                    i2cmbs_pkg::PH_START_A: begin
                        v_enter    = 1'b1;
                        v_enter_ph = i2cmbs_pkg::PH_START_B;
                    end
                    i2cmbs_pkg::PH_START_B: begin
                        n_scl   = 1'b0;
                        n_phase = i2cmbs_pkg::PH_IDLE;
                        n_done  = 1'b1;
                    end
                    i2cmbs_pkg::PH_STOP_A: begin
                        v_enter    = 1'b1;
                        v_enter_ph = i2cmbs_pkg::PH_STOP_B;
                    end
                    i2cmbs_pkg::PH_STOP_B: begin
                        n_phase = i2cmbs_pkg::PH_IDLE;
                        n_done  = 1'b1;
                    end
                    i2cmbs_pkg::PH_WR_LOW: begin
                        v_enter    = 1'b1;
                        v_enter_ph = i2cmbs_pkg::PH_WR_HIGH;
                    end
                    i2cmbs_pkg::PH_WR_HIGH: begin
                        n_shift    = {r_shift[6:0], 1'b0};
                        n_bit      = r_bit + 4'd1;
                        v_enter    = 1'b1;
                        v_enter_ph = (n_bit >= 4'd8) ? i2cmbs_pkg::PH_ACK_LOW
                                                     : i2cmbs_pkg::PH_WR_LOW;
                    end
                    i2cmbs_pkg::PH_ACK_LOW: begin
                        v_enter    = 1'b1;
                        v_enter_ph = i2cmbs_pkg::PH_ACK_HIGH;
                    end
                    i2cmbs_pkg::PH_RD_LOW: begin
                        v_enter    = 1'b1;
                        v_enter_ph = i2cmbs_pkg::PH_RD_HIGH;
                    end
                    i2cmbs_pkg::PH_RD_HIGH: begin
                        n_shift = {r_shift[6:0], i_sda_sampled};
                        n_bit   = r_bit + 4'd1;
                        v_enter = 1'b1;
                        if (n_bit >= 4'd8) begin
                            n_rx       = n_shift;
                            v_enter_ph = i2cmbs_pkg::PH_RA_LOW;
                        end else begin
                            v_enter_ph = i2cmbs_pkg::PH_RD_LOW;
                        end
                    end
                    i2cmbs_pkg::PH_RA_LOW: begin
                        v_enter    = 1'b1;
                        v_enter_ph = i2cmbs_pkg::PH_RA_HIGH;
                    end
                    i2cmbs_pkg::PH_RA_HIGH: begin
                        n_scl   = 1'b0;
                        n_phase = i2cmbs_pkg::PH_IDLE;
                        n_done  = 1'b1;
                    end
                    default: n_phase = i2cmbs_pkg::PH_IDLE;
                endcase
            end
        end

        // entering a phase restarts its tick count and sets the pin levels
        if (v_enter) begin
            n_phase = v_enter_ph;
            n_tick  = 8'd0;
            unique case (v_enter_ph)
                i2cmbs_pkg::PH_START_A: begin
                    n_scl = 1'b1; n_sda = 1'b1; n_drive = 1'b1;
                end
                i2cmbs_pkg::PH_START_B: begin
                    n_scl = 1'b1; n_sda = 1'b0; n_drive = 1'b1;
                end
                i2cmbs_pkg::PH_STOP_A: begin
                    n_scl = 1'b0; n_sda = 1'b0; n_drive = 1'b1;
                end
                i2cmbs_pkg::PH_STOP_B: begin
                    n_scl = 1'b1; n_sda = 1'b1; n_drive = 1'b1;
                end
                i2cmbs_pkg::PH_WR_LOW: begin
                    n_scl = 1'b0; n_sda = n_shift[7]; n_drive = 1'b1;
                end
                i2cmbs_pkg::PH_ACK_LOW, i2cmbs_pkg::PH_RD_LOW: begin
                    n_scl = 1'b0; n_sda = 1'b1; n_drive = 1'b0;
                end
                i2cmbs_pkg::PH_ACK_HIGH: begin
                    n_scl  = 1'b1;
                    n_wait = 10'd0;
                end
                i2cmbs_pkg::PH_RA_LOW: begin
                    n_scl = 1'b0; n_sda = n_nack; n_drive = 1'b1;
                end
                i2cmbs_pkg::PH_WR_HIGH, i2cmbs_pkg::PH_RD_HIGH,
                i2cmbs_pkg::PH_RA_HIGH: n_scl = 1'b1;
                default: n_phase = i2cmbs_pkg::PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= i2cmbs_pkg::PH_IDLE;
            r_bit       <= 4'd0;
            r_tick      <= 8'd0;
            r_wait      <= 10'd0;
            r_shift     <= 8'd0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_drive     <= 1'b1;
            r_nack      <= 1'b0;
            r_fail      <= 1'b0;
            r_rx        <= 8'd0;
            o_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_bit   <= n_bit;
            r_tick  <= n_tick;
            r_wait  <= n_wait;
            r_shift <= n_shift;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
            r_drive <= n_drive;
            r_nack  <= n_nack;
            r_fail  <= n_fail;
            r_rx    <= n_rx;
            if (w_accept) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // result register, loaded with the state as it stands after the item
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            o_scl_level  <= n_scl;
            o_sda_level  <= n_sda;
            o_sda_drive  <= n_drive;
            o_busy_res   <= (n_phase != i2cmbs_pkg::PH_IDLE);
            o_done_res   <= n_done;
            o_ack_failed <= n_fail;
            o_read_data  <= n_rx;
            o_rejected   <= n_rej;
        end
    end

endmodule

`default_nettype wire

[src/i2cmbs_checker.sv]
`default_nettype none

module i2cmbs_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_out_valid,
    input wire logic i_out_ready,
    input wire logic o_sda_level,
    input wire logic o_sda_drive,
    input wire logic o_busy_res,
    input wire logic o_done_res,
    input wire logic o_rejected
);

    // hold a result until it is transferred
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before transfer");

    // a rejected command leaves the running sequence in place
    a_rej_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_rejected |-> o_busy_res)
        else $error("rejected while idle");

    // a finished sequence leaves the engine idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res |-> !o_busy_res && !o_rejected)
        else $error("done while still busy or rejected");

    // a released SDA always reports a high level
    a_release_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_sda_drive |-> o_sda_level)
        else $error("SDA released with low level");

endmodule

bind i2c_master_bit_sequencer i2cmbs_checker u_i2cmbs_checker (.*);

`default_nettype wire

[tb/i2c_master_bit_sequencer_test.sv]
`timescale 1ns / 100ps

module i2c_master_bit_sequencer_test;

    // Request codes past REQ_READ act as plain ticks
    localparam logic [2:0] REQ_SPARE_LO = 3'd5;
    localparam logic [2:0] REQ_SPARE_HI = 3'd7;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       drv;
        logic       busy;
        logic       done;
        logic       fail;
        logic [7:0] rdata;
        logic       rej;
    } t_bus_result;

    typedef struct packed {
        logic [2:0]  req;
        logic [7:0]  tx;
        logic        nack;
        logic        sda;
        logic        lit;
        t_bus_result want;
    } t_step_row;

    localparam t_bus_result BUS_NONE     = '0;
    localparam t_bus_result BUS_IDLE     = {3'b111, 3'b000, 8'h00, 1'b0};
    localparam t_bus_result START_TAKEN  = {3'b111, 3'b100, 8'h00, 1'b0};
    localparam t_bus_result START_REJECT = {3'b111, 3'b100, 8'h00, 1'b1};

    logic                              i_clk = 1'b0;
    logic                              i_rst_n;
    logic                              i_cfg_we;
    logic [i2cmbs_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [i2cmbs_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                              i_in_valid;
    logic                              o_in_ready;
    logic [2:0]                        i_req_type;
    logic [7:0]                        i_tx_byte;
    logic                              i_send_nack;
    logic                              i_sda_sampled;
    logic                              o_out_valid;
    logic                              i_out_ready = 1'b0;
    logic                              o_scl_level;
    logic                              o_sda_level;
    logic                              o_sda_drive;
    logic                              o_busy_res;
    logic                              o_done_res;
    logic                              o_ack_failed;
    logic [7:0]                        o_read_data;
    logic                              o_rejected;

    i2c_master_bit_sequencer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_tx_byte     (i_tx_byte),
        .i_send_nack   (i_send_nack),
        .i_sda_sampled (i_sda_sampled),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_scl_level   (o_scl_level),
        .o_sda_level   (o_sda_level),
        .o_sda_drive   (o_sda_drive),
        .o_busy_res    (o_busy_res),
        .o_done_res    (o_done_res),
        .o_ack_failed  (o_ack_failed),
        .o_read_data   (o_read_data),
        .o_rejected    (o_rejected)
    );

    always #5 i_clk = ~i_clk;

    // Engine state as the bus sequencer should hold it
    logic [7:0]         eng_sst;
    logic [7:0]         eng_half;
    logic [9:0]         eng_timeout;
    i2cmbs_pkg::t_phase eng_phase;
    logic [3:0]         eng_bits;
    logic [7:0]         eng_ticks;
    logic [9:0]         eng_polls;
    logic [7:0]         eng_shift;
    logic               eng_scl;
    logic               eng_sda;
    logic               eng_drv;
    logic               eng_nack;
    logic               eng_fail;
    logic [7:0]         eng_rx;

    t_bus_result pending_levels[$];
    int          errors;
    int          results_seen;
    int          items_sent;
    int          gap_pct;
    int          stall_pct;
    int          hold_left;
    t_bus_result seen_levels;
    t_bus_result owed_levels;

    function automatic void reset_engine();
        eng_sst     = i2cmbs_pkg::RST_START_STOP_TICKS;
        eng_half    = i2cmbs_pkg::RST_HALF_BIT_TICKS;
        eng_timeout = i2cmbs_pkg::RST_ACK_TIMEOUT;
        eng_phase   = i2cmbs_pkg::PH_IDLE;
        eng_bits    = '0;
        eng_ticks   = '0;
        eng_polls   = '0;
        eng_shift   = '0;
        eng_scl     = 1'b1;
        eng_sda     = 1'b1;
        eng_drv     = 1'b1;
        eng_nack    = 1'b0;
        eng_fail    = 1'b0;
        eng_rx      = '0;
    endfunction

    function automatic void enter_phase(input i2cmbs_pkg::t_phase p);
        eng_phase = p;
        eng_ticks = '0;
        case (p)
            i2cmbs_pkg::PH_START_A: begin
                eng_scl = 1'b1; eng_sda = 1'b1; eng_drv = 1'b1;
            end
            i2cmbs_pkg::PH_START_B: begin
                eng_scl = 1'b1; eng_sda = 1'b0; eng_drv = 1'b1;
            end
            i2cmbs_pkg::PH_STOP_A: begin
                eng_scl = 1'b0; eng_sda = 1'b0; eng_drv = 1'b1;
            end
            i2cmbs_pkg::PH_STOP_B: begin
                eng_scl = 1'b1; eng_sda = 1'b1; eng_drv = 1'b1;
            end
            i2cmbs_pkg::PH_WR_LOW: begin
                eng_scl = 1'b0; eng_sda = eng_shift[7]; eng_drv = 1'b1;
            end
            i2cmbs_pkg::PH_ACK_LOW, i2cmbs_pkg::PH_RD_LOW: begin
                eng_scl = 1'b0; eng_sda = 1'b1; eng_drv = 1'b0;
            end
            i2cmbs_pkg::PH_ACK_HIGH: begin
                eng_scl = 1'b1; eng_polls = '0;
            end
            i2cmbs_pkg::PH_RA_LOW: begin
                eng_scl = 1'b0; eng_sda = eng_nack; eng_drv = 1'b1;
            end
            i2cmbs_pkg::PH_WR_HIGH, i2cmbs_pkg::PH_RD_HIGH, i2cmbs_pkg::PH_RA_HIGH: begin
                eng_scl = 1'b1;
            end
            default: begin
                eng_phase = i2cmbs_pkg::PH_IDLE;
            end
        endcase
    endfunction

    // One tick of bus time; returns 1 when a sequence completes
    function automatic logic advance_tick(input logic sda_in);
        int sst;
        int half;
        int span;
        int elapsed;
        sst     = (eng_sst == 8'd0) ? 1 : int'(eng_sst);
        half    = (eng_half == 8'd0) ? 1 : int'(eng_half);
        elapsed = int'(eng_ticks) + 1;
        span    = (eng_phase >= i2cmbs_pkg::PH_START_A && eng_phase <= i2cmbs_pkg::PH_STOP_B)
                  ? sst : half;
        if (eng_phase == i2cmbs_pkg::PH_IDLE)
            return 1'b0;
        if (eng_phase == i2cmbs_pkg::PH_ACK_HIGH) begin
            if (!sda_in) begin
                eng_scl   = 1'b0;
                eng_phase = i2cmbs_pkg::PH_IDLE;
                return 1'b1;
            end
            eng_polls = eng_polls + 10'd1;
            if (eng_polls >= ((eng_timeout == 10'd0) ? 10'd1 : eng_timeout)) begin
                eng_fail = 1'b1;
                enter_phase(i2cmbs_pkg::PH_STOP_A);
            end
            return 1'b0;
        end
        if (elapsed < span) begin
            eng_ticks = 8'(elapsed);
            return 1'b0;
        end
        case (eng_phase)
            i2cmbs_pkg::PH_START_A: enter_phase(i2cmbs_pkg::PH_START_B);
            i2cmbs_pkg::PH_START_B: begin
                eng_scl   = 1'b0;
                eng_phase = i2cmbs_pkg::PH_IDLE;
                return 1'b1;
            end
            i2cmbs_pkg::PH_STOP_A: enter_phase(i2cmbs_pkg::PH_STOP_B);
            i2cmbs_pkg::PH_STOP_B: begin
                eng_phase = i2cmbs_pkg::PH_IDLE;
                return 1'b1;
            end
            i2cmbs_pkg::PH_WR_LOW: enter_phase(i2cmbs_pkg::PH_WR_HIGH);
            i2cmbs_pkg::PH_WR_HIGH: begin
                eng_shift = {eng_shift[6:0], 1'b0};
                eng_bits  = eng_bits + 4'd1;
                enter_phase(eng_bits >= 4'd8 ? i2cmbs_pkg::PH_ACK_LOW
                                             : i2cmbs_pkg::PH_WR_LOW);
            end
            i2cmbs_pkg::PH_ACK_LOW: enter_phase(i2cmbs_pkg::PH_ACK_HIGH);
            i2cmbs_pkg::PH_RD_LOW: enter_phase(i2cmbs_pkg::PH_RD_HIGH);
            i2cmbs_pkg::PH_RD_HIGH: begin
                eng_shift = {eng_shift[6:0], sda_in};
                eng_bits  = eng_bits + 4'd1;
                if (eng_bits >= 4'd8) begin
                    eng_rx = eng_shift;
                    enter_phase(i2cmbs_pkg::PH_RA_LOW);
                end else begin
                    enter_phase(i2cmbs_pkg::PH_RD_LOW);
                end
            end
            i2cmbs_pkg::PH_RA_LOW: enter_phase(i2cmbs_pkg::PH_RA_HIGH);
            default: begin
                eng_scl   = 1'b0;
                eng_phase = i2cmbs_pkg::PH_IDLE;
                return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    function automatic t_bus_result bus_step(input logic [2:0] req, input logic [7:0] tx,
                                             input logic nack, input logic sda_in);
        t_bus_result r;
        logic        fin;
        logic        rej;
        fin = 1'b0;
        rej = 1'b0;
        if (req >= i2cmbs_pkg::REQ_START && req <= i2cmbs_pkg::REQ_READ) begin
            if (eng_phase != i2cmbs_pkg::PH_IDLE) begin
                rej = 1'b1;
            end else begin
                eng_fail = 1'b0;
                eng_bits = '0;
                case (req)
                    i2cmbs_pkg::REQ_START: enter_phase(i2cmbs_pkg::PH_START_A);
                    i2cmbs_pkg::REQ_STOP:  enter_phase(i2cmbs_pkg::PH_STOP_A);
                    i2cmbs_pkg::REQ_WRITE: begin
                        eng_shift = tx;
                        enter_phase(i2cmbs_pkg::PH_WR_LOW);
                    end
                    default: begin
                        eng_nack  = nack;
                        eng_shift = '0;
                        enter_phase(i2cmbs_pkg::PH_RD_LOW);
                    end
                endcase
            end
        end else begin
            fin = advance_tick(sda_in);
        end
        r.scl   = eng_scl;
        r.sda   = eng_sda;
        r.drv   = eng_drv;
        r.busy  = (eng_phase != i2cmbs_pkg::PH_IDLE);
        r.done  = fin;
        r.fail  = eng_fail;
        r.rdata = eng_rx;
        r.rej   = rej;
        return r;
    endfunction

    // Directed opening; rows with lit set carry the levels typed in by hand
    function automatic t_step_row plan_row(input int k);
        t_step_row r;
        case (k)
            0:  r = {i2cmbs_pkg::REQ_TICK,  8'h00, 1'b0, 1'b0, 1'b1, BUS_IDLE};
            1:  r = {REQ_SPARE_HI,          8'hFF, 1'b1, 1'b1, 1'b1, BUS_IDLE};
            2:  r = {REQ_SPARE_LO,          8'h5A, 1'b0, 1'b0, 1'b1, BUS_IDLE};
            3:  r = {i2cmbs_pkg::REQ_START, 8'h00, 1'b0, 1'b1, 1'b1, START_TAKEN};
            4:  r = {i2cmbs_pkg::REQ_WRITE, 8'hFF, 1'b0, 1'b0, 1'b1, START_REJECT};
            5:  r = {i2cmbs_pkg::REQ_READ,  8'h00, 1'b1, 1'b1, 1'b1, START_REJECT};
            6:  r = {i2cmbs_pkg::REQ_STOP,  8'h81, 1'b0, 1'b0, 1'b1, START_REJECT};
            7:  r = {REQ_SPARE_HI,          8'h00, 1'b0, 1'b1, 1'b0, BUS_NONE};
            15: r = {i2cmbs_pkg::REQ_START, 8'hC3, 1'b1, 1'b0, 1'b1, START_TAKEN};
            24: r = {i2cmbs_pkg::REQ_WRITE, 8'h00, 1'b0, 1'b1, 1'b0, BUS_NONE};
            default: r = {i2cmbs_pkg::REQ_TICK, 8'hA5, 1'(k), 1'(k >> 1), 1'b0, BUS_NONE};
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got_v, input int want_v);
        errors++;
        if (errors <= 40)
            $display("%0t: result %0d %s got %0d expected %0d",
                     $realtime, results_seen, what, got_v, want_v);
    endtask

    task automatic check_levels(input t_bus_result got, input t_bus_result want);
        if (got.scl !== want.scl)     report_mismatch("scl_level", got.scl, want.scl);
        if (got.sda !== want.sda)     report_mismatch("sda_level", got.sda, want.sda);
        if (got.drv !== want.drv)     report_mismatch("sda_drive", got.drv, want.drv);
        if (got.busy !== want.busy)   report_mismatch("busy_res", got.busy, want.busy);
        if (got.done !== want.done)   report_mismatch("done_res", got.done, want.done);
        if (got.fail !== want.fail)   report_mismatch("ack_failed", got.fail, want.fail);
        if (got.rdata !== want.rdata) report_mismatch("read_data", got.rdata, want.rdata);
        if (got.rej !== want.rej)     report_mismatch("rejected", got.rej, want.rej);
    endtask

    // Offer one item; entered and left at a falling edge
    task automatic push_item(input logic [2:0] req, input logic [7:0] tx, input logic nack,
                             input logic sda_in, input logic lit, input t_bus_result lit_want);
        t_bus_result want;
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_req_type    <= req;
        i_tx_byte     <= tx;
        i_send_nack   <= nack;
        i_sda_sampled <= sda_in;
        do @(posedge i_clk); while (!o_in_ready);
        want = bus_step(req, tx, nack, sda_in);
        pending_levels.push_back(lit ? lit_want : want);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Issue a command and tick it through to idle, with some noise mixed in
    task automatic run_sequence(input logic [2:0] cmd, input logic never_ack);
        logic [2:0] req;
        logic       sda_in;
        int         pick;
        push_item(cmd, 8'($urandom_range(255)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), 1'b0, BUS_NONE);
        while (eng_phase != i2cmbs_pkg::PH_IDLE) begin
            sda_in = 1'($urandom_range(1));
            if (eng_phase == i2cmbs_pkg::PH_ACK_HIGH)
                sda_in = never_ack ? 1'b1 : ($urandom_range(99) >= 45);
            pick = $urandom_range(99);
            req  = i2cmbs_pkg::REQ_TICK;
            if (pick < 4)
                req = REQ_SPARE_LO + 3'($urandom_range(2));
            else if (pick < 7)
                req = 3'($urandom_range(i2cmbs_pkg::REQ_START, i2cmbs_pkg::REQ_READ));
            push_item(req, 8'($urandom_range(255)), 1'($urandom_range(1)), sda_in,
                      1'b0, BUS_NONE);
        end
    endtask

    task automatic run_traffic(input int budget);
        int first;
        int pick;
        first = items_sent;
        while (items_sent - first < budget) begin
            pick = $urandom_range(99);
            if (pick < 18)
                run_sequence(i2cmbs_pkg::REQ_START, 1'b0);
            else if (pick < 32)
                run_sequence(i2cmbs_pkg::REQ_STOP, 1'b0);
            else if (pick < 62)
                run_sequence(i2cmbs_pkg::REQ_WRITE, $urandom_range(99) < 15);
            else if (pick < 92)
                run_sequence(i2cmbs_pkg::REQ_READ, 1'b0);
            else
                repeat ($urandom_range(1, 4))
                    push_item(3'($urandom_range(7)), 8'($urandom_range(255)),
                              1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0, BUS_NONE);
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_levels.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic set_config(input logic [7:0] sst, input logic [7:0] half,
                              input logic [9:0] timeout);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= i2cmbs_pkg::CFG_START_STOP_TICKS;
        i_cfg_data  <= {2'b00, sst};
        @(negedge i_clk);
        i_cfg_index <= i2cmbs_pkg::CFG_HALF_BIT_TICKS;
        i_cfg_data  <= {2'b00, half};
        @(negedge i_clk);
        i_cfg_index <= i2cmbs_pkg::CFG_ACK_TIMEOUT;
        i_cfg_data  <= timeout;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        eng_sst     = sst;
        eng_half    = half;
        eng_timeout = timeout;
    endtask

    // Result side: stall at random, or hold off for a counted stretch
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen_levels = {o_scl_level, o_sda_level, o_sda_drive, o_busy_res,
                           o_done_res, o_ack_failed, o_read_data, o_rejected};
            if (pending_levels.size() == 0) begin
                report_mismatch("transfer with nothing pending", 1, 0);
            end else begin
                owed_levels = pending_levels.pop_front();
                check_levels(seen_levels, owed_levels);
            end
            results_seen++;
        end
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        t_step_row row;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_req_type    = i2cmbs_pkg::REQ_TICK;
        i_tx_byte     = '0;
        i_send_nack   = 1'b0;
        i_sda_sampled = 1'b1;
        errors        = 0;
        results_seen  = 0;
        items_sent    = 0;
        gap_pct       = 0;
        stall_pct     = 0;
        hold_left     = 0;
        reset_engine();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int k = 0; k < 25; k++) begin
            row = plan_row(k);
            push_item(row.req, row.tx, row.nack, row.sda, row.lit, row.want);
        end
        run_traffic(90);

        drain_results();
        set_config(8'd1, 8'd1, 10'd1);
        gap_pct = 80;
        run_traffic(90);

        // zero durations act as one tick
        drain_results();
        set_config(8'd0, 8'd0, 10'd0);
        gap_pct   = 0;
        stall_pct = 80;
        run_traffic(90);

        drain_results();
        set_config(8'd3, 8'd2, 10'd12);
        gap_pct   = 9;
        stall_pct = 9;
        run_traffic(90);

        // hold the result side off long enough to back up the input
        drain_results();
        set_config(8'd2, 8'd1, 10'd6);
        gap_pct   = 0;
        stall_pct = 0;
        @(posedge i_clk);
        hold_left = 200;
        @(negedge i_clk);
        run_traffic(90);

        // top register values, with transfers that stay short
        drain_results();
        set_config(8'd255, 8'd1, 10'd1023);
        run_sequence(i2cmbs_pkg::REQ_WRITE, 1'b0);
        run_sequence(i2cmbs_pkg::REQ_READ, 1'b0);

        drain_results();
        repeat (4) @(negedge i_clk);
        if (pending_levels.size() != 0)
            report_mismatch("results never delivered", 0, pending_levels.size());
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[i2c_master_bit_sequencer.f]
src/i2cmbs_pkg.sv
src/i2c_master_bit_sequencer.sv
src/i2cmbs_checker.sv
tb/i2c_master_bit_sequencer_test.sv
